@@ design/lbp_pkg.sv @@
// shared types and constants of the lsb-first bit packer
package lbp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HeldW  = 7;
  localparam int unsigned HcntW  = 3;
  localparam int unsigned WordW  = ValueW + HeldW;
  localparam int unsigned NbyteW = 4;
  localparam int unsigned CmdDepth = 2;

  // input item
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] bit_count;
    logic              signed_mode;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             last;
    logic             error;
    logic [HcntW-1:0] pending_count;
    logic [HeldW-1:0] pending_value;
  } out_item_t;

  // class of a command handed from front to back
  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_EMPTY,
    CMD_ERROR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] nbits;
  } cmd_t;

endpackage

@@ design/lbp_front.sv @@
// front end: classifies each item and trims its value to the stored bits
module lbp_front #(
  parameter int unsigned MaxBits = 64
) (
  input  lbp_pkg::in_item_t item_i,
  output lbp_pkg::cmd_t     cmd_o
);

  logic [lbp_pkg::ValueW-1:0] mask;
  logic [lbp_pkg::ValueW-1:0] top;
  logic [lbp_pkg::ValueW-1:0] trimmed;

  // keep the low bit_count bits, force the sign into the top one
  always_comb begin
    mask = ~({lbp_pkg::ValueW{1'b1}} << item_i.bit_count);
    top  = {{(lbp_pkg::ValueW-1){1'b0}}, 1'b1} << (item_i.bit_count - 7'd1);
    trimmed = item_i.value & mask;
    if (item_i.signed_mode) begin
      if (item_i.value[lbp_pkg::ValueW-1]) begin
        trimmed = trimmed | top;
      end else begin
        trimmed = trimmed & ~top;
      end
    end
  end

  // classify
  always_comb begin
    cmd_o.value = trimmed;
    cmd_o.nbits = item_i.bit_count;
    if (item_i.bit_count > lbp_pkg::CountW'(MaxBits)) begin
      cmd_o.kind = lbp_pkg::CMD_ERROR;
    end else if (item_i.bit_count == '0) begin
      cmd_o.kind = lbp_pkg::CMD_EMPTY;
    end else begin
      cmd_o.kind = lbp_pkg::CMD_STORE;
    end
  end

endmodule

@@ design/lbp_cmd_fifo.sv @@
// short command queue between front and back
module lbp_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  lbp_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          rd_valid_o,
  output lbp_pkg::cmd_t rd_data_o
);

  localparam int unsigned PtrW = $clog2(lbp_pkg::CmdDepth);
  localparam int unsigned CntW = $clog2(lbp_pkg::CmdDepth + 1);

  lbp_pkg::cmd_t        slot_q [lbp_pkg::CmdDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(lbp_pkg::CmdDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(lbp_pkg::CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(lbp_pkg::CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ design/lbp_back.sv @@
// back end: merges commands with held bits and emits bytes and status items
module lbp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lbp_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lbp_pkg::out_item_t item_o
);

  logic                        busy_q, busy_d;
  logic [lbp_pkg::NbyteW-1:0]  left_q, left_d;
  logic [lbp_pkg::ValueW-1:0]  word_q, word_d;
  logic [lbp_pkg::HeldW-1:0]   held_q, held_d;
  logic [lbp_pkg::HcntW-1:0]   hcnt_q, hcnt_d;
  logic                        st_err_q, st_err_d;
  logic                        out_valid_q, out_valid_d;
  lbp_pkg::out_item_t          out_q, out_d;

  logic                        res_pop;
  logic                        emit;
  logic                        status_emit;
  logic                        load;
  logic [lbp_pkg::WordW-1:0]   merged;
  logic [lbp_pkg::CountW-1:0]  total;
  logic [lbp_pkg::NbyteW-1:0]  nbytes;
  logic [lbp_pkg::HcntW-1:0]   rem;
  logic [lbp_pkg::HeldW-1:0]   rest;

  // handshake decisions
  always_comb begin
    res_pop     = pop_i && out_valid_q;
    emit        = busy_q && (!out_valid_q || res_pop);
    status_emit = emit && (left_q == '0);
    load        = (!busy_q || status_emit) && cmd_valid_i;
  end

  assign cmd_pop_o = load;
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  // merge the new bits behind the held ones and find the leftover
  always_comb begin
    merged = lbp_pkg::WordW'(held_q)
           | (lbp_pkg::WordW'(cmd_i.value) << hcnt_q);
    total  = lbp_pkg::CountW'(hcnt_q) + cmd_i.nbits;
    nbytes = total[lbp_pkg::CountW-1:3];
    rem    = total[2:0];
    case (nbytes)
      4'd0:    rest = merged[0  +: lbp_pkg::HeldW];
      4'd1:    rest = merged[8  +: lbp_pkg::HeldW];
      4'd2:    rest = merged[16 +: lbp_pkg::HeldW];
      4'd3:    rest = merged[24 +: lbp_pkg::HeldW];
      4'd4:    rest = merged[32 +: lbp_pkg::HeldW];
      4'd5:    rest = merged[40 +: lbp_pkg::HeldW];
      4'd6:    rest = merged[48 +: lbp_pkg::HeldW];
      4'd7:    rest = merged[56 +: lbp_pkg::HeldW];
      default: rest = merged[64 +: lbp_pkg::HeldW];
    endcase
    rest = rest & ~({lbp_pkg::HeldW{1'b1}} << rem);
  end

  // sequencing of bytes and the closing status item
  always_comb begin
    busy_d      = busy_q;
    left_d      = left_q;
    word_d      = word_q;
    held_d      = held_q;
    hcnt_d      = hcnt_q;
    st_err_d    = st_err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    // result register
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      if (left_q != '0) begin
        out_d.out_byte   = word_q[lbp_pkg::ByteW-1:0];
        out_d.byte_valid = 1'b1;
      end else begin
        out_d.last          = 1'b1;
        out_d.error         = st_err_q;
        out_d.pending_count = hcnt_q;
        out_d.pending_value = held_q;
      end
    end else if (res_pop) begin
      out_valid_d = 1'b0;
    end

    // byte walk
    if (emit) begin
      if (left_q != '0) begin
        left_d = left_q - 1'b1;
        word_d = word_q >> lbp_pkg::ByteW;
      end else begin
        busy_d = 1'b0;
      end
    end

    // next command; held bits move to their new value right away
    if (load) begin
      busy_d = 1'b1;
      unique case (cmd_i.kind)
        lbp_pkg::CMD_STORE: begin
          left_d   = nbytes;
          word_d   = merged[lbp_pkg::ValueW-1:0];
          held_d   = rest;
          hcnt_d   = rem;
          st_err_d = 1'b0;
        end
        lbp_pkg::CMD_ERROR: begin
          left_d   = '0;
          st_err_d = 1'b1;
        end
        default: begin
          left_d   = '0;
          st_err_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      left_q      <= '0;
      held_q      <= '0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      left_q      <= left_d;
      held_q      <= held_d;
      hcnt_q      <= hcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    st_err_q <= st_err_d;
    out_q    <= out_d;
  end

endmodule

@@ design/lsb_first_bit_packer_unit.sv @@
// lsb-first bit packer: top level
// Usage: items enter through a queue-style port (push_i, full_o, in_item_i);
// one is taken at a clock edge with push_i high and full_o low. Each item
// stores the low bit_count bits of value behind up to 7 bits held back from
// earlier items, least significant bit first. Results leave through a
// queue-style port (out_item_o, empty_o, pop_i): first every byte the item
// completes (0 to 8), then one status item with the held bits, marked last.
// A bit_count above MaxBits gives only a status item with error set and
// leaves the held bits alone; a count of zero gives only a status item.
// An item taken is written into the command queue, then loaded into the
// back end's byte walker. Throughput: one result per cycle while the
// receiver pops; an item gives (completed bytes + 1) results, 1 to 9, from
// the single byte walker. A two-entry command queue lets new items enter
// while the back end still works. When the receiver stalls, results wait in
// the output register, the walker stops and the command queue fills before
// full_o rises. Reset clears the held bits, the queue and the result port.
module lsb_first_bit_packer_unit #(
  parameter int unsigned MaxBits = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  lbp_pkg::in_item_t  in_item_i,
  output logic               empty_o,
  input  logic               pop_i,
  output lbp_pkg::out_item_t out_item_o
);

  lbp_pkg::cmd_t front_cmd;
  lbp_pkg::cmd_t back_cmd;
  logic          cmd_valid;
  logic          cmd_pop;
  logic          wr_en;

  assign wr_en = push_i && !full_o;

  // classify the incoming item
  lbp_front #(
    .MaxBits (MaxBits)
  ) u_front (
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  // decoupling queue
  lbp_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_data_i  (front_cmd),
    .full_o     (full_o),
    .rd_en_i    (cmd_pop),
    .rd_valid_o (cmd_valid),
    .rd_data_o  (back_cmd)
  );

  // byte emission
  lbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .item_o      (out_item_o)
  );

endmodule
